/* sv/vmf_pkg.sv */
package vmf_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_FILTER_MODE = 3'd0;
   localparam logic [2:0] CSR_LINE_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_H_START     = 3'd2;
   localparam logic [2:0] CSR_H_STEP      = 3'd3;
   localparam logic [2:0] CSR_V_START     = 3'd4;
   localparam logic [2:0] CSR_V_STEP      = 3'd5;
   localparam logic [2:0] CSR_THRESHOLD   = 3'd6;

   // reset values of the configuration registers
   localparam logic [1:0]  RST_FILTER_MODE = 2'd2;
   localparam logic [12:0] RST_LINE_WIDTH  = 13'd1920;
   localparam logic [11:0] RST_H_START     = 12'd399;
   localparam logic [11:0] RST_H_STEP      = 12'd19;
   localparam logic [11:0] RST_V_START     = 12'd178;
   localparam logic [11:0] RST_V_STEP      = 12'd48;
   localparam logic [7:0]  RST_THRESHOLD   = 8'd31;

   // prefilter tap window depth and line counter width
   localparam int TAPS = 6;
   localparam int LCW  = 24;

   // filter modes
   localparam logic [1:0] FM_NONE  = 2'd0;
   localparam logic [1:0] FM_TWO   = 2'd1;
   localparam logic [1:0] FM_THREE = 2'd2;
   localparam logic [1:0] FM_SIX   = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic clr_wr;
      logic accept;
      logic cand_rd;
      logic samp_wr;
      logic d_dec;
      logic finish;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clr_last;
      logic cand_hit;
      logic line_end;
      logic d_zero;
      logic frame_last;
      logic rsp_busy;
   } ctl_sts_type;

   // tap offset i of a mode, relative to the filtered column
   function automatic logic signed [2:0] tap_off(input logic [1:0] mode, input int i);
      logic signed [2:0] r;
      r = 3'sd0;
      unique case (mode)
         FM_NONE:  r = 3'sd0;
         FM_TWO:   r = (i == 0) ? -3'sd1 : 3'sd0;
         FM_THREE: r = (i == 0) ? -3'sd1 : ((i == 2) ? 3'sd1 : 3'sd0);
         FM_SIX:   r = 3'(i - 3);
         default:  r = 3'sd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] tap_count(input logic [1:0] mode);
      logic [2:0] r;
      unique case (mode)
         FM_NONE:  r = 3'd0;
         FM_TWO:   r = 3'd2;
         FM_THREE: r = 3'd3;
         FM_SIX:   r = 3'd6;
         default:  r = 3'd0;
      endcase
      return r;
   endfunction

   // columns of delay that the right-hand taps add
   function automatic logic [1:0] tap_ahead(input logic [1:0] mode);
      logic [1:0] r;
      unique case (mode)
         FM_NONE:  r = 2'd0;
         FM_TWO:   r = 2'd0;
         FM_THREE: r = 2'd1;
         FM_SIX:   r = 2'd2;
         default:  r = 2'd0;
      endcase
      return r;
   endfunction

   // ceil(2^16 / n); exact quotient for sums below 2^13
   function automatic logic [16:0] recip(input logic [2:0] n);
      logic [16:0] r;
      unique case (n)
         3'd1:    r = 17'd65536;
         3'd2:    r = 17'd32768;
         3'd3:    r = 17'd21846;
         3'd4:    r = 17'd16384;
         3'd5:    r = 17'd13108;
         3'd6:    r = 17'd10923;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

/* sv/video_motion_fingerprint_top.sv */
// Sequence: each pixel is accepted, gets one candidate column check, then finishes;
//   a line end adds one check per extra candidate column (up to 2) and each grid
//   sample taken adds a store write before the next check or the finish.
// Throughput: one pixel in flight; a frame-end pixel also holds in its finish cycle
//   while the previous frame result is unaccepted. Its result is valid the next cycle.
// Reset: synchronous, active high; registers take their reset values, then a
//   clearing pass zeroes both banks of the window store.
module video_motion_fingerprint_top #(
   parameter int GRID_ROWS = 16,
   parameter int GRID_COLS = 60,
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_luma,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_fingerprint,
   output logic [9:0]  rsp_changed_count
);
   import vmf_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   vmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   vmf_datapath #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_luma          (req_luma),
      .req_frame_last    (req_frame_last),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_fingerprint   (rsp_fingerprint),
      .rsp_changed_count (rsp_changed_count)
   );

`ifndef NO_ASSERTIONS
   // one pixel at a time: busy right after a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while previous pixel in progress");

   // store write of a sample always follows its read
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.samp_wr |-> $past(cmd.cand_rd))
      else $error("sample write without store read");

   // a frame result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(sts.frame_last && sts.rsp_busy))
      else $error("frame result overwritten");
`endif
endmodule

/* sv/vmf_ram.sv */
module vmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1920
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* sv/vmf_ctrl.sv */
module vmf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  vmf_pkg::ctl_sts_type sts,
   output vmf_pkg::ctl_cmd_type cmd
);
   import vmf_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CAND  = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       more;

   // another candidate column remains at the line end
   assign more = sts.line_end && !sts.d_zero;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CAND;
            end
         end
         ST_CAND: begin
            if (sts.cand_hit) begin
               cmd.cand_rd = 1'b1;
               state_in    = ST_WRITE;
            end else if (more) begin
               cmd.d_dec = 1'b1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_WRITE: begin
            cmd.samp_wr = 1'b1;
            if (more) begin
               cmd.d_dec = 1'b1;
               state_in  = ST_CAND;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!(sts.frame_last && sts.rsp_busy)) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* sv/vmf_datapath.sv */
module vmf_datapath #(
   parameter int GRID_ROWS = 16,
   parameter int GRID_COLS = 60,
   parameter int MAX_WIDTH = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [12:0]          csr_wdata,
   input  logic [7:0]           req_luma,
   input  logic                 req_frame_last,
   input  vmf_pkg::ctl_cmd_type cmd,
   output vmf_pkg::ctl_sts_type sts,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_fingerprint,
   output logic [9:0]           rsp_changed_count
);
   import vmf_pkg::*;

   localparam int GRID_SIZE = GRID_ROWS * GRID_COLS;
   localparam int GIW = $clog2(GRID_SIZE + 1);
   localparam int GCW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int AW  = $clog2(2 * GRID_SIZE);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = CW + 1;
   localparam int NCW = ((CW > 12) ? CW : 12) + 1;

   // configuration registers
   logic [1:0]  mode_ff;
   logic [12:0] lwidth_ff;
   logic [11:0] hstart_ff, hstep_ff, vstart_ff, vstep_ff;
   logic [7:0]  thresh_ff;

   // item and frame state
   logic [7:0]       taps_ff [TAPS];
   logic             last_ff;
   logic [1:0]       d_ff;
   logic             bank_ff;
   logic [CW-1:0]    col_ff;
   logic [LCW-1:0]   line_ff;
   logic [NCW-1:0]   ncol_ff;
   logic [LCW:0]     nline_ff;
   logic [GIW-1:0]   grid_ff;
   logic [GCW-1:0]   gcol_ff;
   logic [9:0]       total_ff;
   logic [AW-1:0]    clr_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_fp_ff;
   logic [9:0]       rsp_cnt_ff;
   logic [7:0]       filt_ff;

   logic [WW-1:0]    weff;
   logic             line_end;
   logic [11:0]      hstep_eff, vstep_eff;
   logic             row_live;
   logic [7:0]       filt_val;
   logic [AW-1:0]    samp_addr;
   logic [7:0]       old_val;
   logic [7:0]       diff;
   logic [NCW:0]     ncol_sum;

   // effective line width, clamped to 1..MAX_WIDTH
   always_comb begin
      if (lwidth_ff == 13'd0) begin
         weff = WW'(1);
      end else if ({1'b0, lwidth_ff} > 14'(MAX_WIDTH)) begin
         weff = WW'(MAX_WIDTH);
      end else begin
         weff = WW'(lwidth_ff);
      end
   end

   assign line_end  = last_ff || ((WW'(col_ff) + WW'(1)) >= weff);
   assign hstep_eff = (hstep_ff == 12'd0) ? 12'd1 : hstep_ff;
   assign vstep_eff = (vstep_ff == 12'd0) ? 12'd1 : vstep_ff;
   assign row_live  = ({1'b0, line_ff} == nline_ff) && (grid_ff < GIW'(GRID_SIZE));

   // next grid column; saturates past every reachable column
   assign ncol_sum  = {1'b0, ncol_ff} + (NCW+1)'(hstep_eff);

   // box prefilter of the column d_ff behind the newest pixel
   always_comb begin
      logic [10:0]       sum;
      logic [2:0]        used;
      logic signed [4:0] k;
      logic [27:0]       prod;
      sum  = '0;
      used = '0;
      for (int i = 0; i < TAPS; i++) begin
         k = $signed({3'b000, d_ff}) - 5'(tap_off(mode_ff, i));
         if ((3'(i) < tap_count(mode_ff)) && (k >= 0) && (k < 5'sd6) &&
             (CW'(k[2:0]) <= col_ff)) begin
            sum  = sum + 11'(taps_ff[k[2:0]]);
            used = used + 3'd1;
         end
      end
      prod = 28'(sum) * 28'(recip(used));
      if (mode_ff == FM_NONE) begin
         filt_val = taps_ff[3'(d_ff)];
      end else begin
         filt_val = prod[23:16];
      end
   end

   // store address of the current grid sample in the older bank
   assign samp_addr = bank_ff ? (AW'(GRID_SIZE) + AW'(grid_ff)) : AW'(grid_ff);

   assign diff = (filt_ff > old_val) ? (filt_ff - old_val) : (old_val - filt_ff);

   // two-frame grid window store, both banks in one memory
   vmf_ram #(.WIDTH(8), .DEPTH(2 * GRID_SIZE)) u_window (
      .clock (clock),
      .we    (cmd.clr_wr || cmd.samp_wr),
      .waddr (cmd.clr_wr ? clr_ff : samp_addr),
      .wdata (cmd.clr_wr ? 8'd0 : filt_ff),
      .re    (cmd.cand_rd),
      .raddr (samp_addr),
      .rdata (old_val)
   );

   // status to the controller
   always_comb begin
      sts.clr_last   = (clr_ff == AW'(2 * GRID_SIZE - 1));
      sts.cand_hit   = row_live && (CW'(d_ff) <= col_ff) &&
                       (NCW'(col_ff - CW'(d_ff)) == ncol_ff);
      sts.line_end   = line_end;
      sts.d_zero     = (d_ff == 2'd0);
      sts.frame_last = last_ff;
      sts.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // filtered sample latched with the store read, frame result at the frame-end finish
   always_ff @(posedge clock) begin
      if (cmd.cand_rd) filt_ff <= filt_val;
      if (cmd.finish && last_ff) begin
         rsp_fp_ff  <= total_ff[9:2];
         rsp_cnt_ff <= total_ff;
      end
   end

   // control and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= RST_FILTER_MODE;
         lwidth_ff    <= RST_LINE_WIDTH;
         hstart_ff    <= RST_H_START;
         hstep_ff     <= RST_H_STEP;
         vstart_ff    <= RST_V_START;
         vstep_ff     <= RST_V_STEP;
         thresh_ff    <= RST_THRESHOLD;
         for (int i = 0; i < TAPS; i++) taps_ff[i] <= 8'd0;
         last_ff      <= 1'b0;
         d_ff         <= 2'd0;
         bank_ff      <= 1'b0;
         col_ff       <= '0;
         line_ff      <= '0;
         ncol_ff      <= NCW'(RST_H_START);
         nline_ff     <= (LCW+1)'(RST_V_START);
         grid_ff      <= '0;
         gcol_ff      <= '0;
         total_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // register writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_FILTER_MODE: mode_ff   <= csr_wdata[1:0];
               CSR_LINE_WIDTH:  lwidth_ff <= csr_wdata;
               CSR_H_START:     hstart_ff <= csr_wdata[11:0];
               CSR_H_STEP:      hstep_ff  <= csr_wdata[11:0];
               CSR_V_START:     vstart_ff <= csr_wdata[11:0];
               CSR_V_STEP:      vstep_ff  <= csr_wdata[11:0];
               CSR_THRESHOLD:   thresh_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end

         if (cmd.clr_wr) clr_ff <= clr_ff + AW'(1);

         // new pixel enters the tap window
         if (cmd.accept) begin
            for (int i = TAPS - 1; i > 0; i--) taps_ff[i] <= taps_ff[i-1];
            taps_ff[0] <= req_luma;
            last_ff    <= req_frame_last;
            d_ff       <= tap_ahead(mode_ff);
         end

         if (cmd.d_dec) d_ff <= d_ff - 2'd1;

         // compare against two frames back and advance the grid
         if (cmd.samp_wr) begin
            if ((diff > thresh_ff) && (total_ff != 10'h3FF)) total_ff <= total_ff + 10'd1;
            grid_ff <= grid_ff + GIW'(1);
            if (gcol_ff == GCW'(GRID_COLS - 1)) begin
               gcol_ff  <= '0;
               nline_ff <= nline_ff + (LCW+1)'(vstep_eff);
               ncol_ff  <= NCW'(hstart_ff);
            end else begin
               gcol_ff <= gcol_ff + GCW'(1);
               ncol_ff <= ncol_sum[NCW] ? '1 : ncol_sum[NCW-1:0];
            end
         end

         // end of item: line and frame bookkeeping
         if (cmd.finish) begin
            if (last_ff) begin
               bank_ff  <= ~bank_ff;
               col_ff   <= '0;
               line_ff  <= '0;
               grid_ff  <= '0;
               gcol_ff  <= '0;
               total_ff <= '0;
               ncol_ff  <= NCW'(hstart_ff);
               nline_ff <= (LCW+1)'(vstart_ff);
            end else if (line_end) begin
               // skip the rest of an unfinished grid row
               if (row_live) begin
                  grid_ff  <= grid_ff + GIW'(GRID_COLS) - GIW'(gcol_ff);
                  gcol_ff  <= '0;
                  nline_ff <= nline_ff + (LCW+1)'(vstep_eff);
                  ncol_ff  <= NCW'(hstart_ff);
               end
               col_ff <= '0;
               if (line_ff != {LCW{1'b1}}) line_ff <= line_ff + LCW'(1);
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end

         // result register
         if (cmd.finish && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fingerprint   = rsp_fp_ff;
   assign rsp_changed_count = rsp_cnt_ff;
endmodule
